[sv/prq_pkg.sv]
// Package for the priority ready queue.
// Holds sizes, command and status codes, and the cell interface types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package prq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 8;
	localparam int PRIO_BITS   = 8;
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] CMD_PUSH   = 3'd0;
	localparam logic [2:0] CMD_INSERT = 3'd1;
	localparam logic [2:0] CMD_POP    = 3'd2;
	localparam logic [2:0] CMD_PEEK   = 3'd3;
	localparam logic [2:0] CMD_REMOVE = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// one queue entry as it moves between neighbor cells
	typedef struct packed {
		logic                 valid;
		logic [ID_BITS-1:0]   id;
		logic [PRIO_BITS-1:0] prio;
	} entry_t;

	// command broadcast to every cell; the do_* flags are already qualified
	typedef struct packed {
		logic                 do_push;
		logic                 do_insert;
		logic                 do_pop;
		logic                 do_remove;
		logic [ID_BITS-1:0]   id;
		logic [PRIO_BITS-1:0] prio;
	} bcast_t;

endpackage
`default_nettype wire

[sv/prq_cell.sv]
// One slot of the priority ready queue cell chain.
// Holds one entry; takes data from its left or right neighbor or the new item.
// Depends on prq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prq_cell
	import prq_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire bcast_t bcast,
	input  wire entry_t left,
	input  wire entry_t right,
	input  wire logic   hit_in,
	output entry_t      entry,
	output logic        hit_out
);

	logic                 valid_q;
	logic [ID_BITS-1:0]   id_q;
	logic [PRIO_BITS-1:0] prio_q;
	logic                 match;
	logic                 load;
	entry_t               nxt;
	entry_t               new_e;

	assign entry = '{valid: valid_q, id: id_q, prio: prio_q};
	assign new_e = '{valid: 1'b1, id: bcast.id, prio: bcast.prio};

	// insert: first slot whose priority is >= new; remove: first id match
	always_comb begin
		match = 1'b0;
		if (bcast.do_insert) begin
			match = valid_q && (bcast.prio <= prio_q);
		end else if (bcast.do_remove) begin
			match = valid_q && (bcast.id == id_q);
		end
	end

	assign hit_out = hit_in | match;

	always_comb begin
		load = 1'b0;
		nxt  = entry;
		if (bcast.do_push) begin
			if (!valid_q && left.valid) begin
				load = 1'b1;
				nxt  = new_e;
			end
		end else if (bcast.do_insert) begin
			if (hit_in) begin
				load = 1'b1;
				nxt  = left;
			end else if (match || (!valid_q && left.valid)) begin
				load = 1'b1;
				nxt  = new_e;
			end
		end else if (bcast.do_pop) begin
			load = 1'b1;
			nxt  = right;
		end else if (bcast.do_remove) begin
			if (hit_out) begin
				load = 1'b1;
				nxt  = right;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			id_q   <= nxt.id;
			prio_q <= nxt.prio;
		end
	end

endmodule
`default_nettype wire

[sv/priority_ready_queue.sv]
// Top level of the priority ready queue: command decode, cell chain, result.
// Depends on prq_pkg and prq_cell.
//
// Usage:
//   A command is taken at a rising edge with start high and busy low. busy
//   stays low, so a new command may be issued every cycle: one item per cycle.
//   Commands: push tail, priority insert, pop head, peek head, remove id.
//   The result (value, status, count, is_empty) appears in the cycle after the
//   command is taken, marked by a one-cycle done strobe; the receiver cannot
//   stall it, so it must take the result in that cycle.
//   The cell chain has a single register stage: all slots compare against the
//   command at once, the first-hit flag ripples through the chain, and every
//   cell shifts or loads in the same edge.
//   Push to a full queue is dropped with status full; pop, peek or remove on
//   an empty queue give status empty; remove of an absent id gives not found.
//   Reset (arst_n low) empties the queue and clears done; slot contents are
//   left as they were and are never read before being written.
`timescale 1ns / 1ps
`default_nettype none
module priority_ready_queue
	import prq_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [2:0]           command,
	input  wire logic [ID_BITS-1:0]   thread_id,
	input  wire logic [PRIO_BITS-1:0] priority_req,
	output logic                      done,
	output logic [7:0]                value,
	output logic [1:0]                status,
	output logic [4:0]                count,
	output logic                      is_empty
);

	entry_t                 cells [QUEUE_DEPTH];
	logic   [QUEUE_DEPTH:0] hit;
	logic   [QUEUE_DEPTH-1:0] valid_vec;
	bcast_t                 bcast;
	logic                   accept;
	logic                   full;
	logic                   empty;
	logic                   found;
	logic   [CNT_BITS-1:0]  count_q;
	logic                   done_q;
	logic   [ID_BITS-1:0]   value_q;
	logic   [1:0]           status_q;
	logic   [ID_BITS-1:0]   value_d;
	logic   [1:0]           status_d;
	logic   [CNT_BITS-1:0]  count_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign empty  = !cells[0].valid;
	assign full   = cells[QUEUE_DEPTH-1].valid;
	assign found  = hit[QUEUE_DEPTH];
	assign hit[0] = 1'b0;

	always_comb begin
		bcast           = '0;
		bcast.id        = thread_id;
		bcast.prio      = priority_req;
		bcast.do_push   = accept && (command == CMD_PUSH) && !full;
		bcast.do_insert = accept && (command == CMD_INSERT) && !full;
		bcast.do_pop    = accept && (command == CMD_POP) && !empty;
		bcast.do_remove = accept && (command == CMD_REMOVE) && !empty;
	end

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			entry_t left_e;
			entry_t right_e;
			if (gi == 0) begin : g_head
				assign left_e = '{valid: 1'b1, id: '0, prio: '0};
			end else begin : g_mid
				assign left_e = cells[gi-1];
			end
			if (gi == QUEUE_DEPTH - 1) begin : g_tail
				assign right_e = '{valid: 1'b0, id: '0, prio: '0};
			end else begin : g_nxt
				assign right_e = cells[gi+1];
			end
			prq_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.bcast   (bcast),
				.left    (left_e),
				.right   (right_e),
				.hit_in  (hit[gi]),
				.entry   (cells[gi]),
				.hit_out (hit[gi+1])
			);
			assign valid_vec[gi] = cells[gi].valid;
		end
	endgenerate

	always_comb begin
		value_d  = '0;
		status_d = ST_OK;
		count_d  = count_q;
		case (command)
			CMD_PUSH, CMD_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			CMD_POP: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					value_d = cells[0].id;
					count_d = count_q - 1'b1;
				end
			end
			CMD_PEEK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					value_d = cells[0].id;
				end
			end
			CMD_REMOVE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (!found) begin
					status_d = ST_NOTFOUND;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q  <= value_d;
			status_q <= status_d;
		end
	end

	assign done     = done_q;
	assign value    = 8'(value_q);
	assign status   = status_q;
	assign count    = 5'(count_q);
	assign is_empty = (count_q == '0);

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == count_q)
		else $error("entry count disagrees with occupied cells");

	a_cells_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + 1'b1) & valid_vec) == '0)
		else $error("occupied cells are not packed at the head");

	a_done_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("no result after a taken command");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (count_q == CNT_BITS'(QUEUE_DEPTH)))
		else $error("full status reported on a queue that is not full");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		bcast.do_pop |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop did not shrink the queue");

endmodule
`default_nettype wire
